[rtl/core/lru_id_cache_tracker_macros.svh]
`ifndef LRU_ID_CACHE_TRACKER_MACROS_SVH
`define LRU_ID_CACHE_TRACKER_MACROS_SVH

// same-cycle implication
`define LICT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lru tracker assertion failed");

// next-cycle implication
`define LICT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lru tracker assertion failed");

`endif

[rtl/core/lict_pkg.sv]
`default_nettype none

package lict_pkg;

   localparam int ID_W  = 31;
   localparam int CFG_W = 5;

   typedef struct packed {
      logic            update;
      logic            write;
      logic [ID_W-1:0] key;
   } lict_ctl_type;

endpackage

`default_nettype wire

[rtl/core/lict_cell.sv]
`default_nettype none

module lict_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lict_pkg::lict_ctl_type      ctl,
   input  wire logic                        rst_range,
   input  wire logic                        wr_range,
   input  wire logic [lict_pkg::ID_W-1:0]   prev_id,
   input  wire logic                        prev_valid,
   input  wire logic                        found_in,
   input  wire logic                        next_range,
   output logic [lict_pkg::ID_W-1:0]        id_out,
   output logic                             valid_out,
   output logic                             range_out,
   output logic                             found_out,
   output logic                             tail_valid
);
   import lict_pkg::*;

   logic [ID_W-1:0] id_ff;
   logic            valid_ff;
   logic            range_ff;
   logic            shift;
   logic            match;

   assign match      = valid_ff && (id_ff == ctl.key);
   assign found_out  = found_in || match;
   assign shift      = ctl.update && range_ff && !found_in;
   assign tail_valid = valid_ff && range_ff && !next_range;
   assign id_out     = id_ff;
   assign valid_out  = valid_ff;
   assign range_out  = range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         range_ff <= rst_range;
      end else if (ctl.write) begin
         range_ff <= wr_range;
         if (!wr_range) begin
            valid_ff <= 1'b0;
         end
      end else if (shift) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift && !ctl.write) begin
         id_ff <= prev_id;
      end
   end

endmodule

`default_nettype wire

[rtl/core/lru_id_cache_tracker.sv]
`default_nettype none

// Fully associative LRU tracker built as a row of CAPACITY cells ordered by
// recency, cell 0 most recent. A request is transferred when start is high
// and busy is low; the next cycle (busy high) compares the id against every
// cell and shifts the cells down to the hit position, or through the whole
// capacity in use on a miss. The result is strobed on rsp_valid for exactly
// one cycle after that and cannot be held off, so it must be captured then;
// a new request may be transferred in that same cycle, but none is taken while
// busy is high, during the single compare-and-shift pass over the cell row.
// A capacity write takes effect at once and drops the least recent ids past
// the new capacity; zero counts as one.

`include "lru_id_cache_tracker_macros.svh"

module lru_id_cache_tracker #(
   parameter int CAPACITY = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [lict_pkg::ID_W-1:0]   req_node_id,
   output logic                             rsp_valid,
   output logic                             rsp_hit,
   output logic                             rsp_evicted,
   output logic [lict_pkg::ID_W-1:0]        rsp_evicted_id,
   input  wire logic                        csr_we,
   input  wire logic [lict_pkg::CFG_W-1:0]  csr_wdata
);
   import lict_pkg::*;

   localparam int RESET_CAP = 16;

   logic            busy_ff,   busy_in;
   logic [ID_W-1:0] key_ff,    key_in;
   logic            valid_ff;
   logic            hit_ff,    hit_in;
   logic            ev_ff,     ev_in;
   logic [ID_W-1:0] ev_id_ff,  ev_id_in;

   logic [CFG_W-1:0] eff_cap;
   lict_ctl_type     ctl;
   logic             accept;

   logic [ID_W-1:0]   cell_id    [CAPACITY];
   logic [CAPACITY-1:0] cell_valid;
   logic [CAPACITY-1:0] cell_range;
   logic [CAPACITY-1:0] cell_tail;
   logic [CAPACITY:0]   found;
   logic [CAPACITY-1:0] wr_range;
   logic [CAPACITY-1:0] rst_range;
   logic [ID_W-1:0]     tail_id;

   assign accept  = start && !busy_ff;
   assign busy    = busy_ff;
   assign eff_cap = (csr_wdata == '0) ? CFG_W'(1) : csr_wdata;

   assign ctl.update = busy_ff;
   assign ctl.write  = csr_we;
   assign ctl.key    = key_ff;

   assign found[0] = 1'b0;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         assign wr_range[g]  = (32'(g) < 32'(eff_cap));
         assign rst_range[g] = (32'(g) < 32'(RESET_CAP));
         lict_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .rst_range  (rst_range[g]),
            .wr_range   (wr_range[g]),
            .prev_id    ((g == 0) ? key_ff : cell_id[(g == 0) ? 0 : g-1]),
            .prev_valid ((g == 0) ? 1'b1 : cell_valid[(g == 0) ? 0 : g-1]),
            .found_in   (found[g]),
            .next_range ((g == CAPACITY-1) ? 1'b0
                                           : cell_range[(g == CAPACITY-1) ? g : g+1]),
            .id_out     (cell_id[g]),
            .valid_out  (cell_valid[g]),
            .range_out  (cell_range[g]),
            .found_out  (found[g+1]),
            .tail_valid (cell_tail[g])
         );
      end
   endgenerate

   always_comb begin
      tail_id = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (cell_tail[i]) begin
            tail_id = tail_id | cell_id[i];
         end
      end
   end

   always_comb begin
      busy_in  = accept;
      key_in   = accept ? req_node_id : key_ff;
      hit_in   = found[CAPACITY];
      ev_in    = !hit_in && (|cell_tail);
      ev_id_in = ev_in ? tail_id : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (busy_ff) begin
         hit_ff   <= hit_in;
         ev_ff    <= ev_in;
         ev_id_ff <= ev_id_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_hit        = hit_ff;
   assign rsp_evicted    = ev_ff;
   assign rsp_evicted_id = ev_id_ff;

   `LICT_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy && !rsp_valid)
   `LICT_ASSERT_NEXT(a_busy_result, clock, reset, busy, rsp_valid && !busy)
   `LICT_ASSERT_IMPLIES(a_hit_no_evict, clock, reset, rsp_valid, !(rsp_hit && rsp_evicted))
   `LICT_ASSERT_IMPLIES(a_evict_id_zero, clock, reset, rsp_valid && !rsp_evicted,
                        rsp_evicted_id == '0)
   `LICT_ASSERT_IMPLIES(a_valid_prefix, clock, reset, 1'b1,
                        (cell_valid & ~{cell_valid[CAPACITY-2:0], 1'b1}) == '0)

endmodule

`default_nettype wire
